### rtl/pcg_pkg.sv
// Shared types, constants and the XSH-RR output permutation for the PCG32 block.
// No dependencies; imported by every module of the block.
package pcg_pkg;

    localparam logic [63:0] PCG_MULT        = 64'd6364136223846793005;
    localparam logic [63:0] PCG_RESET_STATE = 64'h853c49e6748fea9b;
    localparam logic [63:0] PCG_RESET_INC   = 64'hda3e39cb94b95bdb;

    localparam int XSH_SHIFT_A = 18;
    localparam int XSH_SHIFT_B = 27;
    localparam int ROT_LSB     = 59;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_DRAW = 2'd0,
        FUNC_SEED = 2'd1,
        FUNC_JUMP = 2'd2
    } t_func;

    typedef enum logic {
        CFG_SEED_STATE    = 1'b0,
        CFG_SEED_SEQUENCE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_func       func;
        logic [63:0] distance;
    } t_item;

    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] mixed;
        logic [31:0] x;
        logic [4:0]  r;
        logic [63:0] both;
        mixed = (s >> XSH_SHIFT_A) ^ s;
        x     = mixed[XSH_SHIFT_B +: 32];
        r     = s[ROT_LSB +: 5];
        both  = {x, x} >> r;
        return both[31:0];
    endfunction

endpackage

### rtl/pcg_front.sv
// Front end: accepts command items, drops those that change nothing, queues the rest.
// Depends on pcg_pkg.
module pcg_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_func,
    input  logic [63:0]      i_jump_distance,
    input  logic [63:0]      i_seed_state,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output pcg_pkg::t_item   o_cmd
);
    import pcg_pkg::*;

    t_item                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp, n_wp;
    logic [QUEUE_AW-1:0]  r_rp, n_rp;
    logic [QUEUE_CW-1:0]  r_cnt, n_cnt;
    logic                 w_keep;
    logic                 w_push;
    logic                 w_pop;

    always_comb begin
        unique case (i_func)
            FUNC_DRAW: w_keep = 1'b1;
            FUNC_SEED: w_keep = (i_seed_state != 64'd0);
            FUNC_JUMP: w_keep = (i_jump_distance != 64'd0);
            default:   w_keep = 1'b0;
        endcase
    end

    assign o_ready     = (r_cnt != QUEUE_CW'(QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_queue[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        priority if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wp] <= '{func: t_func'(i_func), distance: i_jump_distance};
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count above depth");
`endif

endmodule

### rtl/pcg_mul.sv
// Iterative 64x64 multiply-add, low 64 bits of a*b+c, on one 32x32 multiplier.
// Three partial products in turn after operand capture. Depends on pcg_pkg.
module pcg_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_c,
    output logic        o_done,
    output logic [63:0] o_result
);
    import pcg_pkg::*;

    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_LH = 2'd1;
    localparam logic [1:0] PH_HL = 2'd2;

    logic [63:0] r_a, r_b, r_c;
    logic [63:0] r_acc, n_acc;
    logic [1:0]  r_ph, n_ph;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] w_x, w_y;
    logic [63:0] w_prod;

    always_comb begin
        unique case (r_ph)
            PH_LL:   begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            PH_LH:   begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            PH_HL:   begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
        endcase
    end

    assign w_prod = w_x * w_y;

    always_comb begin
        n_acc  = r_acc;
        n_ph   = r_ph;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_ph   = PH_LL;
            n_busy = 1'b1;
        end else if (r_busy) begin
            unique case (r_ph)
                PH_LL: begin
                    n_acc = w_prod + r_c;
                    n_ph  = PH_LH;
                end
                PH_LH: begin
                    n_acc = r_acc + {w_prod[31:0], 32'd0};
                    n_ph  = PH_HL;
                end
                PH_HL: begin
                    n_acc  = r_acc + {w_prod[31:0], 32'd0};
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_LL;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_c <= i_c;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiply started while busy");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && ($past(r_ph) == PH_HL))
        else $error("done without final partial product");
`endif

endmodule

### rtl/pcg_back.sv
// Back end: holds PCG state and increment, runs draw, reseed and jump-ahead on pcg_mul,
// and drives the result register. Depends on pcg_pkg and pcg_mul.
module pcg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  pcg_pkg::t_item   i_cmd,
    input  logic [63:0]      i_seed_state,
    input  logic [63:0]      i_seed_sequence,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_random_word
);
    import pcg_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    localparam logic [2:0] OP_STEP = 3'd0;
    localparam logic [2:0] OP_AM   = 3'd1;
    localparam logic [2:0] OP_AP   = 3'd2;
    localparam logic [2:0] OP_P    = 3'd3;
    localparam logic [2:0] OP_M    = 3'd4;
    localparam logic [2:0] OP_FIN  = 3'd5;

    logic [1:0]  r_seq;
    logic [2:0]  r_op;
    logic [63:0] r_state;
    logic [63:0] r_inc;
    logic [63:0] r_acc_m, r_acc_p, r_m, r_p, r_dist;
    logic        r_out_valid;
    logic [31:0] r_out_word;

    logic        w_pop;
    logic        w_pop_draw;
    logic        w_out_free;
    logic [63:0] w_s, w_q, w_new_inc;
    logic [63:0] w_a, w_b, w_c;
    logic        w_mul_start;
    logic        w_mul_done;
    logic [63:0] w_mul_res;

    assign w_out_free  = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_seq == S_IDLE) && ((i_cmd.func != FUNC_DRAW) || w_out_free);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_pop_draw  = w_pop && (i_cmd.func == FUNC_DRAW);
    assign w_mul_start = (r_seq == S_ISSUE);

    always_comb begin
        w_s       = i_seed_state & i_seed_sequence;
        w_s       = (w_s == 64'd0) ? PCG_RESET_STATE : w_s;
        w_q       = (i_seed_sequence == 64'd0) ? PCG_RESET_INC : i_seed_sequence;
        w_new_inc = {w_q[62:0], 1'b1};
    end

    always_comb begin
        w_c = 64'd0;
        unique case (r_op)
            OP_STEP: begin w_a = r_state;     w_b = PCG_MULT; w_c = r_inc;   end
            OP_AM:   begin w_a = r_acc_m;     w_b = r_m;                     end
            OP_AP:   begin w_a = r_acc_p;     w_b = r_m;      w_c = r_p;     end
            OP_P:    begin w_a = r_m + 64'd1; w_b = r_p;                     end
            OP_M:    begin w_a = r_m;         w_b = r_m;                     end
            OP_FIN:  begin w_a = r_acc_m;     w_b = r_state;  w_c = r_acc_p; end
            default: begin w_a = r_state;     w_b = PCG_MULT; w_c = r_inc;   end
        endcase
    end

    pcg_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_c      (w_c),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_op        <= OP_STEP;
            r_state     <= PCG_RESET_STATE;
            r_inc       <= PCG_RESET_INC;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop_draw) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_seq)
                S_IDLE: begin
                    if (w_pop) begin
                        r_seq <= S_ISSUE;
                        unique case (i_cmd.func)
                            FUNC_DRAW: begin
                                r_op <= OP_STEP;
                            end
                            FUNC_SEED: begin
                                r_inc   <= w_new_inc;
                                r_state <= w_new_inc + w_s;
                                r_op    <= OP_STEP;
                            end
                            FUNC_JUMP: begin
                                r_op <= i_cmd.distance[0] ? OP_AM : OP_P;
                            end
                            default: begin
                                r_seq <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ISSUE: begin
                    r_seq <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_mul_done) begin
                        r_seq <= S_ISSUE;
                        unique case (r_op)
                            OP_AM: r_op <= OP_AP;
                            OP_AP: r_op <= (r_dist[63:1] != 63'd0) ? OP_P : OP_FIN;
                            OP_P:  r_op <= OP_M;
                            OP_M:  r_op <= r_dist[1] ? OP_AM : OP_P;
                            default: begin
                                r_state <= w_mul_res;
                                r_seq   <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_seq <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_draw) begin
            r_out_word <= xsh_rr(r_state);
        end
        if (w_pop && (i_cmd.func == FUNC_JUMP)) begin
            r_acc_m <= 64'd1;
            r_acc_p <= 64'd0;
            r_m     <= PCG_MULT;
            r_p     <= r_inc;
            r_dist  <= i_cmd.distance;
        end else if ((r_seq == S_WAIT) && w_mul_done) begin
            unique case (r_op)
                OP_AM: r_acc_m <= w_mul_res;
                OP_AP: r_acc_p <= w_mul_res;
                OP_P:  r_p     <= w_mul_res;
                OP_M: begin
                    r_m    <= w_mul_res;
                    r_dist <= r_dist >> 1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

`ifndef ASSERT_OFF
    a_inc_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inc[0])
        else $error("stream increment even");
    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_draw |=> r_out_valid)
        else $error("draw without result");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_seq == S_WAIT))
        else $error("multiply result outside wait");
`endif

endmodule

### rtl/pcg32_generator_with_jump_ahead.sv
// PCG32 (XSH-RR, 64-bit LCG) generator with stream select and jump-ahead.
// Top level: configuration registers, front end and back end; depends on pcg_pkg, pcg_front and pcg_back.
//
// Usage:
//   Command channel i_valid/o_ready carries i_func (0 draw, 1 reseed, 2 jump)
//   and i_jump_distance. Result channel o_valid/i_ready carries o_random_word,
//   one item per draw; reseed, jump and code 3 give no item.
//   Configuration channel i_cfg_valid/o_cfg_ready writes seed_state (index 0)
//   and seed_sequence (index 1); write only while the block is idle.
//   A draw command waits in the front-end queue; once the back end is idle and
//   the result register is free, the back end takes it and registers its word.
//   Each 64x64 multiply-add runs on a single 32x32 multiplier; a draw or
//   reseed runs one multiply-add in the back end. A jump over a distance of
//   n significant bits with k bits set runs 2 * (n - 1) + 2 * k + 1
//   multiply-adds; jumps by zero and reseeds with a zero seed_state are
//   dropped at the front end.
//   A two-item queue lets commands be taken while the back end is busy.
//   Reset: state and increment return to their defaults, seeds clear to zero,
//   queue and result register empty. A stalled receiver holds the result
//   register, and later draws wait in the queue.
module pcg32_generator_with_jump_ahead (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_jump_distance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_random_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import pcg_pkg::*;

    logic [63:0] r_seed_state;
    logic [63:0] r_seed_sequence;
    logic        w_cmd_valid;
    logic        w_cmd_ready;
    t_item       w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_state    <= 64'd0;
            r_seed_sequence <= 64'd0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SEED_STATE:    r_seed_state    <= i_cfg_data;
                CFG_SEED_SEQUENCE: r_seed_sequence <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pcg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_jump_distance (i_jump_distance),
        .i_seed_state    (r_seed_state),
        .o_cmd_valid     (w_cmd_valid),
        .i_cmd_ready     (w_cmd_ready),
        .o_cmd           (w_cmd)
    );

    pcg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_ready     (w_cmd_ready),
        .i_cmd           (w_cmd),
        .i_seed_state    (r_seed_state),
        .i_seed_sequence (r_seed_sequence),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_random_word   (o_random_word)
    );

endmodule

### bench/tb_top.sv
// Testbench for pcg32_generator_with_jump_ahead: draws, reseeds and jumps under
// random idling, checked word by word against a predictor of the PCG32 state.
// Depends on pcg_pkg and the RTL of the block.
module tb_top;
    import pcg_pkg::*;

    localparam logic [1:0] FUNC_UNUSED      = 2'd3;
    localparam int         RANDOM_PER_PHASE = 213;
    localparam int         SETTLE_CYCLES    = 4000;
    localparam int         WATCHDOG_LIMIT   = 20000;

    class pcg_word_predictor;
        logic [63:0] lcg_state;
        logic [63:0] stream_inc;
        logic [63:0] seed_state;
        logic [63:0] seed_seq;
        logic [31:0] pending_words[$];
        int          errors;

        function new();
            lcg_state  = PCG_RESET_STATE;
            stream_inc = PCG_RESET_INC;
            seed_state = '0;
            seed_seq   = '0;
            errors     = 0;
        endfunction

        function logic [63:0] lcg_advance(logic [63:0] s);
            return s * PCG_MULT + stream_inc;
        endfunction

        function logic [31:0] permute(logic [63:0] s);
            logic [63:0] mixed;
            logic [31:0] x;
            int unsigned rot;
            mixed = (s >> XSH_SHIFT_A) ^ s;
            x     = 32'(mixed >> XSH_SHIFT_B);
            rot   = 32'(s >> ROT_LSB);
            return (x >> rot) | (x << ((32 - rot) & 31));
        endfunction

        function logic [63:0] jump_state(logic [63:0] s, logic [63:0] distance);
            logic [63:0] acc_m;
            logic [63:0] acc_p;
            logic [63:0] m;
            logic [63:0] p;
            acc_m = 64'd1;
            acc_p = 64'd0;
            m     = PCG_MULT;
            p     = stream_inc;
            while (distance != 0) begin
                if (distance[0]) begin
                    acc_m = acc_m * m;
                    acc_p = acc_p * m + p;
                end
                p        = (m + 64'd1) * p;
                m        = m * m;
                distance = distance >> 1;
            end
            return acc_m * s + acc_p;
        endfunction

        function void write_reg(logic idx, logic [63:0] data);
            if (idx == CFG_SEED_STATE)
                seed_state = data;
            else
                seed_seq = data;
        endfunction

        function void note_command(logic [1:0] func, logic [63:0] distance);
            logic [63:0] s;
            logic [63:0] q;
            case (func)
                FUNC_DRAW: begin
                    pending_words.push_back(permute(lcg_state));
                    lcg_state = lcg_advance(lcg_state);
                end
                FUNC_SEED: begin
                    if (seed_state != 0) begin
                        s = seed_state & seed_seq;
                        if (s == 0)
                            s = PCG_RESET_STATE;
                        q = seed_seq;
                        if (q == 0)
                            q = PCG_RESET_INC;
                        stream_inc = {q[62:0], 1'b1};
                        lcg_state  = lcg_advance(64'd0) + s;
                        lcg_state  = lcg_advance(lcg_state);
                    end
                end
                FUNC_JUMP: begin
                    lcg_state = jump_state(lcg_state, distance);
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [31:0] actual);
            logic [31:0] want;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected random_word, expected none actual %h", $time, actual);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (actual !== want) begin
                $display("%0t: random_word expected %h actual %h", $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [1:0]  i_func          = '0;
    logic [63:0] i_jump_distance = '0;
    logic        i_ready         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        i_cfg_index     = 1'b0;
    logic [63:0] i_cfg_data      = '0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_random_word;
    logic        o_cfg_ready;

    pcg_word_predictor sb = new();

    int sender_idle_pct  = 0;
    int receiver_idle_pct = 0;
    int quiet_cycles     = 0;

    pcg32_generator_with_jump_ahead DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_jump_distance(i_jump_distance),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_word  (o_random_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_word(o_random_word);
        i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] jump_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return rand64();
        if (pick < 20)
            return 64'($urandom_range(0, 65535));
        return 64'($urandom_range(0, 300));
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                sender_idle_pct   = 26;
                receiver_idle_pct = 75;
            end
            1: begin
                sender_idle_pct   = 75;
                receiver_idle_pct = 26;
            end
            default: begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_cmd(logic [1:0] func, logic [63:0] distance);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= func;
        i_jump_distance <= distance;
        do @(posedge i_clk); while (!o_ready);
        sb.note_command(func, distance);
    endtask

    task automatic write_seeds(logic [63:0] state_seed, logic [63:0] seq_seed);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SEED_STATE;
        i_cfg_data  <= state_seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_SEED_STATE, state_seed);
        i_cfg_index <= CFG_SEED_SEQUENCE;
        i_cfg_data  <= seq_seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_SEED_SEQUENCE, seq_seed);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off until every word is in, then let queued jumps and reseeds finish.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          phase;
        int          sent;
        int          pick;
        logic [63:0] rs;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(2);
        send_cmd(FUNC_DRAW, 64'd0);
        send_cmd(FUNC_DRAW, '1);
        send_cmd(FUNC_SEED, rand64());
        send_cmd(FUNC_DRAW, rand64());
        send_cmd(FUNC_JUMP, 64'd0);
        send_cmd(FUNC_DRAW, 64'd0);
        send_cmd(FUNC_JUMP, 64'd1);
        send_cmd(FUNC_DRAW, 64'd0);
        send_cmd(FUNC_UNUSED, '1);
        send_cmd(FUNC_DRAW, 64'd0);
        send_cmd(FUNC_JUMP, '1);
        send_cmd(FUNC_DRAW, 64'd0);
        send_cmd(FUNC_JUMP, 64'h8000_0000_0000_0000);
        send_cmd(FUNC_DRAW, 64'd0);
        settle();
        write_seeds('1, '1);
        send_cmd(FUNC_SEED, 64'd0);
        send_cmd(FUNC_DRAW, 64'd0);
        send_cmd(FUNC_DRAW, 64'd0);
        settle();
        // seeds that share no bit: the default state seed takes over
        write_seeds(64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00);
        send_cmd(FUNC_SEED, 64'd0);
        send_cmd(FUNC_DRAW, 64'd0);
        settle();
        write_seeds(64'h0123_4567_89ab_cdef, 64'd0);
        send_cmd(FUNC_SEED, 64'd0);
        send_cmd(FUNC_DRAW, 64'd0);

        for (phase = 0; phase < 6; phase++) begin
            settle();
            rs = rand64() | 64'd1;
            case (phase)
                0: write_seeds(rand64(), rand64());
                1: write_seeds(rand64(), 64'd0);
                2: write_seeds(64'd0, '1);
                3: write_seeds('1, rand64());
                4: write_seeds(64'd1, '1);
                default: write_seeds(rs, ~rs);
            endcase
            set_idling(phase / 2);
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    send_cmd(FUNC_UNUSED, rand64());
                end else begin
                    if (pick < 8)
                        send_cmd(FUNC_SEED, rand64());
                    else if (pick < 18)
                        send_cmd(FUNC_JUMP, jump_length());
                    else
                        send_cmd(FUNC_DRAW, rand64());
                    sent++;
                end
            end
        end

        i_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.pending_words.size() != 0)
            $display("%0t: %0d random_word items never arrived", $time,
                     sb.pending_words.size());
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/pcg_pkg.sv
rtl/pcg_front.sv
rtl/pcg_mul.sv
rtl/pcg_back.sv
rtl/pcg32_generator_with_jump_ahead.sv
bench/tb_top.sv
